FILE: rtl/spq_pkg.sv
package spq_pkg;

  localparam int SPQ_DEPTH   = 16;
  localparam int ID_W        = 37;
  localparam int TICKET_W    = 14;
  localparam int PRIO_W      = 4;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POPPED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DROP   = 3'd2;
  localparam logic [2:0] OP_POP    = 3'd3;
  localparam logic [2:0] OP_EMPTY  = 3'd4;

  typedef struct packed {
    logic                command;
    logic [ID_W-1:0]     entry_id;
    logic [TICKET_W-1:0] ticket_number;
    logic [PRIO_W-1:0]   priority_req;
  } spq_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_id;
    logic [TICKET_W-1:0] out_ticket;
    logic [PRIO_W-1:0]   out_priority;
    logic [OCC_W-1:0]    occupancy;
  } spq_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [TICKET_W-1:0] ticket;
    logic [PRIO_W-1:0]   prio;
  } spq_slot_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic [2:0] op;
  } spq_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

FILE: rtl/spq_ctrl.sv
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_ctrl_t ctrl
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctrl.load  = 1'b0;
    ctrl.op    = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_pop) begin
          ctrl.op = stat.empty ? OP_EMPTY : OP_POP;
        end else begin
          ctrl.op = stat.full ? OP_DROP : OP_INSERT;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
    end
  end

endmodule

FILE: rtl/spq_datapath.sv
module spq_datapath #(
  parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::spq_req_t  req,
  input  spq_pkg::spq_ctrl_t ctrl,
  output spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_rsp_t  rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  spq_req_t       req_q;
  spq_slot_t      slots [DEPTH];
  spq_slot_t      slots_next [DEPTH];
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic [DEPTH-1:0] gt;
  logic [DEPTH-1:0] gt_prev;
  spq_slot_t      new_slot;

  assign stat.is_pop = (req_q.command == CMD_POP);
  assign stat.full   = (count == CW'(DEPTH));
  assign stat.empty  = (count == '0);

  assign new_slot.id     = req_q.entry_id;
  assign new_slot.ticket = req_q.ticket_number;
  assign new_slot.prio   = req_q.priority_req;

  // stored entries that must move behind the new one; sorted, so gt is a
  // contiguous run ending at count-1
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      gt[k] = (CW'(k) < count) && (slots[k].prio > req_q.priority_req);
    end
  end

  // gt of the slot in front; slot 0 has none
  assign gt_prev = {gt[DEPTH-2:0], 1'b0};

  always_comb begin
    count_next = count;
    for (int k = 0; k < DEPTH; k++) begin
      slots_next[k] = slots[k];
    end
    unique case (ctrl.op)
      OP_INSERT: begin
        count_next = count + CW'(1);
        for (int k = 0; k < DEPTH; k++) begin
          if (gt_prev[k]) begin
            slots_next[k] = slots[k-1];
          end else if (gt[k] || CW'(k) == count) begin
            slots_next[k] = new_slot;
          end
        end
      end
      OP_POP: begin
        count_next = count - CW'(1);
        for (int k = 0; k < DEPTH - 1; k++) begin
          slots_next[k] = slots[k+1];
        end
      end
      OP_NONE, OP_DROP, OP_EMPTY: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_q <= req;
    end
    for (int k = 0; k < DEPTH; k++) begin
      slots[k] <= slots_next[k];
    end
    if (ctrl.op != OP_NONE) begin
      rsp.out_id       <= '0;
      rsp.out_ticket   <= '0;
      rsp.out_priority <= '0;
      rsp.occupancy    <= OCC_W'(count_next);
      case (ctrl.op)
        OP_INSERT: rsp.status <= ST_INSERTED;
        OP_DROP:   rsp.status <= ST_DROPPED;
        OP_POP: begin
          rsp.status       <= ST_POPPED;
          rsp.out_id       <= slots[0].id;
          rsp.out_ticket   <= slots[0].ticket;
          rsp.out_priority <= slots[0].prio;
        end
        default:   rsp.status <= ST_EMPTY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

FILE: rtl/stable_priority_queue.sv
// Channel   Ports              Handshake
// -------   -----------------  ---------------------------------------------
// command   start, busy, req   taken at a rising edge with start high, busy low
// result    done, rsp          valid for the single cycle that done is high
//
// Each item is handled in order: the command is registered, then all
// slots compare against its priority in parallel and shift in one step.
// done rises the cycle after that; a new item may be taken in that same cycle.
// Synchronous reset empties the queue; slot contents are not cleared.
// The result side has no stall: the result is shown for one cycle only.
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_req_t req,
  output logic              done,
  output spq_pkg::spq_rsp_t rsp
);
  import spq_pkg::*;

  spq_ctrl_t ctrl;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  spq_datapath #(
    .DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .ctrl (ctrl),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  // Tracks the service order of the queue and the responses still owed.
  class spq_tracker;
    spq_slot_t   held[$];
    spq_rsp_t    owed[$];
    int unsigned mismatches = 0;

    function void note_command(spq_req_t r);
      spq_rsp_t  exp_rsp;
      spq_slot_t s;
      int        pos;
      exp_rsp = '0;
      if (r.command == CMD_INSERT) begin
        if (held.size() >= SPQ_DEPTH) begin
          exp_rsp.status = ST_DROPPED;
        end else begin
          s.id     = r.entry_id;
          s.ticket = r.ticket_number;
          s.prio   = r.priority_req;
          // goes behind every entry of lower or equal priority
          pos = 0;
          while (pos < held.size() && held[pos].prio <= s.prio) pos++;
          held.insert(pos, s);
          exp_rsp.status = ST_INSERTED;
        end
      end else if (held.size() == 0) begin
        exp_rsp.status = ST_EMPTY;
      end else begin
        s = held.pop_front();
        exp_rsp.status       = ST_POPPED;
        exp_rsp.out_id       = s.id;
        exp_rsp.out_ticket   = s.ticket;
        exp_rsp.out_priority = s.prio;
      end
      exp_rsp.occupancy = OCC_W'(held.size());
      owed.push_back(exp_rsp);
    endfunction

    function void check_response(spq_rsp_t got);
      spq_rsp_t exp_rsp;
      if (owed.size() == 0) begin
        $error("unexpected result: status %0d occupancy %0d", got.status, got.occupancy);
        mismatches++;
        return;
      end
      exp_rsp = owed.pop_front();
      if (got.status !== exp_rsp.status) begin
        $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
        mismatches++;
      end
      if (got.out_id !== exp_rsp.out_id) begin
        $error("out_id: expected %0d, got %0d", exp_rsp.out_id, got.out_id);
        mismatches++;
      end
      if (got.out_ticket !== exp_rsp.out_ticket) begin
        $error("out_ticket: expected %0d, got %0d", exp_rsp.out_ticket, got.out_ticket);
        mismatches++;
      end
      if (got.out_priority !== exp_rsp.out_priority) begin
        $error("out_priority: expected %0d, got %0d", exp_rsp.out_priority,
               got.out_priority);
        mismatches++;
      end
      if (got.occupancy !== exp_rsp.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp_rsp.occupancy, got.occupancy);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  spq_req_t req = '0;
  logic     done;
  spq_rsp_t rsp;

  spq_tracker tracker = new;

  stable_priority_queue uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) tracker.check_response(rsp);
  end

  function automatic spq_req_t make_item(logic cmd, logic [ID_W-1:0] id,
                                         logic [TICKET_W-1:0] ticket,
                                         logic [PRIO_W-1:0] prio);
    spq_req_t r;
    r.command       = cmd;
    r.entry_id      = id;
    r.ticket_number = ticket;
    r.priority_req  = prio;
    return r;
  endfunction

  function automatic spq_req_t random_item(int unsigned insert_pct, bit narrow_prio);
    spq_req_t r;
    r.command               = ($urandom_range(99, 0) < insert_pct) ? CMD_INSERT : CMD_POP;
    r.entry_id[31:0]        = $urandom;
    r.entry_id[ID_W-1:32]   = (ID_W-32)'($urandom_range(31, 0));
    r.ticket_number         = TICKET_W'($urandom_range(16383, 0));
    // a narrow priority range piles up ties
    r.priority_req          = narrow_prio ? PRIO_W'($urandom_range(3, 0))
                                          : PRIO_W'($urandom_range(15, 0));
    return r;
  endfunction

  // holds start high until the item is taken; leaves it high
  task automatic issue(input spq_req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    tracker.note_command(r);
  endtask

  task automatic hold_off(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    logic [PRIO_W-1:0] prio_list [16];
    logic [ID_W-1:0]   id;
    logic [TICKET_W-1:0] ticket;
    int unsigned       insert_pct;
    bit                narrow_prio;
    bit                quiet;

    prio_list   = '{4'd15, 4'd0, 4'd7, 4'd7, 4'd0, 4'd15, 4'd3, 4'd7,
                    4'd8, 4'd1, 4'd7, 4'd0, 4'd15, 4'd12, 4'd7, 4'd4};
    insert_pct  = 50;
    narrow_prio = 1'b0;
    quiet       = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // pop on empty, fill with ties and extremes, insert on full, partial drain
    issue(make_item(CMD_POP, '0, '0, '0));
    for (int k = 0; k < 16; k++) begin
      id     = {(ID_W-32)'($urandom_range(31, 0)), $urandom};
      ticket = TICKET_W'($urandom_range(16383, 0));
      if (k == 0) begin
        id     = '1;
        ticket = '1;
      end else if (k == 1) begin
        id     = '0;
        ticket = '0;
      end
      issue(make_item(CMD_INSERT, id, ticket, prio_list[k]));
    end
    issue(make_item(CMD_INSERT, '1, '1, '0));
    for (int k = 0; k < 6; k++) issue(make_item(CMD_POP, '1, '1, '1));

    for (int n = 0; n < 1500; n++) begin
      // phases lean toward insert or pop so the queue swings between full and empty
      if (n % 50 == 0) begin
        case ($urandom_range(3, 0))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          2:       insert_pct = 75;
          default: insert_pct = 90;
        endcase
        narrow_prio = 1'($urandom_range(1, 0));
        quiet       = ($urandom_range(2, 0) == 0);
      end
      if (n == 700) begin
        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
      end
      issue(random_item(insert_pct, narrow_prio));
      if (n < 1300 && !quiet && $urandom_range(5, 0) == 0)
        hold_off($urandom_range(17, 1));
    end
    start <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("stable_priority_queue regression: pass");
    end else begin
      $display("stable_priority_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("stable_priority_queue regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/stable_priority_queue.sv
tb/sv/tb_top.sv
